// ----- rtl/core/qbnr_pkg.sv -----
// ----------------------------------------------------------------------------
// qbnr_pkg: shared types and constants
// Port widths, register indexes and the unit status struct used by the
// quantized batch-norm requantizer.
// ----------------------------------------------------------------------------
package qbnr_pkg;

  // Stream payload widths
  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_EPSILON    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_MIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_MAX  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUT_MAXABS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_INNER_SIZE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHAN_COUNT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELU_EN    = 3'd6;

  // Item kinds
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Arithmetic constants
  localparam logic [31:0] DEQ_DIVISOR = 32'd255;  // code range of uint8
  localparam logic [31:0] REQ_SCALE2  = 32'd254;  // 2 * 127 for half-up rounding
  localparam logic [6:0]  Q_LIMIT     = 7'd127;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/core/quantized_batch_norm_requant_top.sv -----
// Load item: runs the square root unit followed by the shared divider; no result
//   transfer.
// Sample item: uses the shared divider for the requantize step, which is skipped
//   when output_max_abs is 0; one result transfer.
// One item in flight; in_tready is high only while idle; a held result stalls ST_FIN.
// Reset (synchronous, rst_n low): registers to defaults, counters zero, tables undefined.
// ----------------------------------------------------------------------------
// quantized_batch_norm_requant_top: batch normalization with int8 requantize
// Stores per-channel slope/offset from load items and maps uint8 samples
// through dequantize, normalize, optional ReLU and int8 requantize.
// ----------------------------------------------------------------------------
module quantized_batch_norm_requant_top #(
  parameter int MAX_CHANNELS = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: sample_code[7:0], channel_index[15:8], scale_gamma[47:16],
  //   shift_beta[79:48], running_mean[111:80], running_variance[142:112], pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [qbnr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: opcode[0], restart[1]
  input  logic [qbnr_pkg::IN_TUSER_W-1:0]     in_tuser,
  // out_tdata: quantized_out[7:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [qbnr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [qbnr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [qbnr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import qbnr_pkg::*;

  localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_LIM = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
  localparam int X_W    = 32 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int RT_W   = X_W / 2;
  localparam int DIV_N  = (32 + FRAC_BITS > 41) ? 32 + FRAC_BITS : 41;
  localparam int DIV_D  = 32;
  localparam int PS_W   = 64 - FRAC_BITS;
  // fold steps that bring a 40-bit dividend below 256 for the divide by 255
  localparam int DEQ_STEPS = 6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_P1, ST_S_D1, ST_S_D1W, ST_S_P2, ST_S_N, ST_S_P3, ST_S_D2, ST_S_D2W,
    ST_FIN,
    ST_L_SQ, ST_L_SQW, ST_L_DIV, ST_L_DW, ST_L_MUL, ST_L_P, ST_L_OF
  } state_t;

  // --------------------------------------------------------------------------
  // Helpers
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  state_t             state_r;
  logic               out_tvalid_r;
  logic [7:0]         out_tdata_r;

  logic [16:0]        eps_r;
  logic signed [31:0] imin_r;
  logic signed [31:0] imax_r;
  logic [30:0]        omax_r;
  logic [20:0]        inner_r;
  logic [8:0]         chcnt_r;
  logic               relu_r;

  logic [19:0]        pos_r;
  logic [7:0]         ch_r;

  logic [7:0]         idx_r;
  logic signed [31:0] gamma_r;
  logic signed [31:0] beta_r;
  logic signed [31:0] mean_r;
  logic [30:0]        var_r;

  logic [CH_AW-1:0]   rd_addr_r;
  logic signed [31:0] slope_rd_r;
  logic signed [31:0] ofs_rd_r;

  logic [31:0]        mul_a_r;
  logic [31:0]        mul_b_r;
  logic               neg_r;
  logic signed [31:0] slope_r;
  logic [7:0]         res_r;

  logic [39:0]        deq_x_r;
  logic [32:0]        deq_q_r;
  logic [2:0]         deq_cnt_r;

  logic signed [31:0] slope_mem [MAX_CHANNELS];
  logic signed [31:0] ofs_mem   [MAX_CHANNELS];

  // --------------------------------------------------------------------------
  // Input field split
  logic               in_opcode;
  logic               in_restart;
  logic [7:0]         in_code;
  logic [7:0]         in_chidx;
  logic               in_xfer;

  assign in_opcode  = in_tuser[0];
  assign in_restart = in_tuser[1];
  assign in_code    = in_tdata[7:0];
  assign in_chidx   = in_tdata[15:8];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Position counters
  logic [19:0] pos_base;
  logic [7:0]  ch_base;
  logic [20:0] inner_eff;
  logic [8:0]  nch_eff;
  logic [7:0]  ch_sel;
  logic [20:0] pos_inc;
  logic [8:0]  ch_inc;
  logic [19:0] pos_nxt;
  logic [7:0]  ch_nxt;

  always_comb begin
    pos_base = in_restart ? 20'd0 : pos_r;
    ch_base  = in_restart ? 8'd0 : ch_r;
    if (inner_r == 21'd0)            inner_eff = 21'd1;
    else if (inner_r > 21'h100000)   inner_eff = 21'h100000;
    else                             inner_eff = inner_r;
    if (chcnt_r == 9'd0)             nch_eff = 9'd1;
    else if (chcnt_r > 9'(CH_LIM))   nch_eff = 9'(CH_LIM);
    else                             nch_eff = chcnt_r;
    ch_sel  = ({1'b0, ch_base} < nch_eff) ? ch_base : 8'd0;
    pos_inc = {1'b0, pos_base} + 21'd1;
    ch_inc  = {1'b0, ch_base} + 9'd1;
    if (pos_inc >= inner_eff) begin
      pos_nxt = 20'd0;
      ch_nxt  = (ch_inc >= nch_eff) ? 8'd0 : ch_inc[7:0];
    end else begin
      pos_nxt = pos_inc[19:0];
      ch_nxt  = ch_base;
    end
  end

  // --------------------------------------------------------------------------
  // Shared units
  logic [63:0]      mul_p;
  logic             div_start;
  logic [DIV_N-1:0] div_num;
  logic [DIV_D-1:0] div_den;
  logic [DIV_N-1:0] div_quo;
  unit_sts_t        div_sts;
  logic             sq_start;
  logic [X_W-1:0]   sq_x;
  logic [RT_W-1:0]  sq_root;
  unit_sts_t        sq_sts;
  logic [31:0]      var_sum;

  qbnr_mul u_mul (
    .clk (clk),
    .a_i (mul_a_r),
    .b_i (mul_b_r),
    .p_o (mul_p)
  );

  qbnr_div #(.N_W(DIV_N), .D_W(DIV_D)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  qbnr_isqrt #(.X_W(X_W)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_start),
    .x_i     (sq_x),
    .sts_o   (sq_sts),
    .root_o  (sq_root)
  );

  // Square root operand: (variance + epsilon) in Q, scaled once more
  assign var_sum  = {1'b0, var_r} + 32'(eps_r);
  assign sq_x     = X_W'(var_sum) << FRAC_BITS;
  assign sq_start = (state_r == ST_L_SQ);

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_S_D2: begin
        div_start = 1'b1;
        div_num   = DIV_N'(mul_p) + DIV_N'(omax_r);
        div_den   = {omax_r, 1'b0};
      end
      ST_L_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_N'(mag32(gamma_r)) << FRAC_BITS;
        div_den   = DIV_D'(sq_root);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath glue around the shared units
  logic [PS_W-1:0]    p_shift;
  logic signed [65:0] p_ext;
  logic signed [65:0] p_sgn;
  logic [32:0]        deq_q;
  logic signed [33:0] real_w;
  logic signed [31:0] real32;
  logic signed [31:0] n_sat;
  logic signed [31:0] n_act;
  logic signed [31:0] ofs_new;
  logic signed [31:0] slope_new;
  logic [6:0]         q_mag;

  always_comb begin
    p_shift = mul_p[63:FRAC_BITS];
    p_ext   = $signed(66'(p_shift));
    p_sgn   = neg_r ? -p_ext : p_ext;
    // divide by 255: folded residue is below 256, one more when it equals 255
    deq_q   = deq_q_r + 33'(deq_x_r == 40'(DEQ_DIVISOR));
    // dequantized real value, quotient carries the sign of the range
    real_w  = 34'(imin_r) + (neg_r ? -$signed({1'b0, deq_q}) : $signed({1'b0, deq_q}));
    real32  = real_w[31:0];
    // normalized value with optional ReLU
    n_sat   = sat32(p_sgn + 66'(ofs_rd_r));
    n_act   = (relu_r && n_sat[31]) ? 32'sd0 : n_sat;
    // channel offset
    ofs_new = sat32(66'(beta_r) - p_sgn);
    // slope saturates to the int32 range with the sign of gamma
    if (gamma_r[31]) begin
      slope_new = (div_quo > DIV_N'(33'h080000000)) ? 32'sh80000000 : -$signed(div_quo[31:0]);
    end else begin
      slope_new = (div_quo > DIV_N'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(div_quo[31:0]);
    end
    q_mag = (div_quo > DIV_N'(Q_LIMIT)) ? Q_LIMIT : div_quo[6:0];
  end

  // --------------------------------------------------------------------------
  // Channel tables
  logic             mem_we;
  logic [CH_AW-1:0] wr_addr;

  assign mem_we  = (state_r == ST_L_OF) && ({24'd0, idx_r} < 32'(MAX_CHANNELS));
  assign wr_addr = CH_AW'(idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slope_mem[wr_addr] <= slope_r;
      ofs_mem[wr_addr]   <= ofs_new;
    end
    slope_rd_r <= slope_mem[rd_addr_r];
    ofs_rd_r   <= ofs_mem[rd_addr_r];
  end

  // --------------------------------------------------------------------------
  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      eps_r        <= 17'd66;
      imin_r       <= 32'sd0;
      imax_r       <= 32'sd16711680;
      omax_r       <= 31'd8323072;
      inner_r      <= 21'd1;
      chcnt_r      <= 9'd1;
      relu_r       <= 1'b0;
      pos_r        <= 20'd0;
      ch_r         <= 8'd0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_EPSILON:    eps_r   <= cfg_wdata[16:0];
          CFG_INPUT_MIN:  imin_r  <= $signed(cfg_wdata);
          CFG_INPUT_MAX:  imax_r  <= $signed(cfg_wdata);
          CFG_OUT_MAXABS: omax_r  <= cfg_wdata[30:0];
          CFG_INNER_SIZE: inner_r <= cfg_wdata[20:0];
          CFG_CHAN_COUNT: chcnt_r <= cfg_wdata[8:0];
          CFG_RELU_EN:    relu_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      // result transfer taken; ST_FIN reloads the register itself
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_r   <= in_chidx;
            gamma_r <= $signed(in_tdata[47:16]);
            beta_r  <= $signed(in_tdata[79:48]);
            mean_r  <= $signed(in_tdata[111:80]);
            var_r   <= in_tdata[142:112];
            if (in_opcode == OP_SAMPLE) begin
              pos_r     <= pos_nxt;
              ch_r      <= ch_nxt;
              rd_addr_r <= CH_AW'(ch_sel);
              // code * |max - min|, sign kept in neg_r
              mul_a_r   <= 32'(in_code);
              mul_b_r   <= 32'(33'(imax_r) - 33'(imin_r) >= 0 ?
                             33'(imax_r) - 33'(imin_r) : 33'(imin_r) - 33'(imax_r));
              neg_r     <= (imax_r < imin_r);
              state_r   <= ST_S_P1;
            end else begin
              state_r   <= ST_L_SQ;
            end
          end
        end
        ST_S_P1:  state_r <= ST_S_D1;
        ST_S_D1: begin
          deq_x_r   <= mul_p[39:0];
          deq_q_r   <= 33'd0;
          deq_cnt_r <= 3'(DEQ_STEPS);
          state_r   <= ST_S_D1W;
        end
        ST_S_D1W: begin
          if (deq_cnt_r != 3'd0) begin
            // x = 256*a + b = 255*a + (a + b)
            deq_q_r   <= deq_q_r + 33'(deq_x_r[39:8]);
            deq_x_r   <= 40'(deq_x_r[39:8]) + 40'(deq_x_r[7:0]);
            deq_cnt_r <= deq_cnt_r - 3'd1;
          end else begin
            mul_a_r <= mag32(real32);
            mul_b_r <= mag32(slope_rd_r);
            neg_r   <= real32[31] ^ slope_rd_r[31];
            state_r <= ST_S_P2;
          end
        end
        ST_S_P2:  state_r <= ST_S_N;
        ST_S_N: begin
          mul_a_r <= REQ_SCALE2;
          mul_b_r <= mag32(n_act);
          neg_r   <= n_act[31];
          if (omax_r == 31'd0) begin
            res_r   <= 8'd0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_S_P3;
          end
        end
        ST_S_P3:  state_r <= ST_S_D2;
        ST_S_D2:  state_r <= ST_S_D2W;
        ST_S_D2W: begin
          if (div_sts.done) begin
            res_r   <= neg_r ? -{1'b0, q_mag} : {1'b0, q_mag};
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= res_r;
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_L_SQ:  state_r <= ST_L_SQW;
        ST_L_SQW: begin
          if (sq_sts.done) begin
            if (sq_root == '0) begin
              slope_r <= 32'sd0;
              state_r <= ST_L_MUL;
            end else begin
              state_r <= ST_L_DIV;
            end
          end
        end
        ST_L_DIV: state_r <= ST_L_DW;
        ST_L_DW: begin
          if (div_sts.done) begin
            slope_r <= slope_new;
            state_r <= ST_L_MUL;
          end
        end
        ST_L_MUL: begin
          mul_a_r <= mag32(mean_r);
          mul_b_r <= mag32(slope_r);
          neg_r   <= mean_r[31] ^ slope_r[31];
          state_r <= ST_L_P;
        end
        ST_L_P:   state_r <= ST_L_OF;
        ST_L_OF:  state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Assertions
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_sts.done |-> (state_r == ST_L_SQW))
    else $error("square root finished outside its wait state");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_opcode == OP_LOAD) && !out_tvalid) |=> !out_tvalid)
    else $error("load item produced a result");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != 8'h80))
    else $error("result outside -127..127");

endmodule

// ----- rtl/core/qbnr_mul.sv -----
// ----------------------------------------------------------------------------
// qbnr_mul: shared unsigned multiplier
// 32 x 32 unsigned product with a registered result.
// ----------------------------------------------------------------------------
module qbnr_mul (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_r;

  // Product register
  always_ff @(posedge clk) begin
    p_r <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_r;

endmodule

// ----- rtl/core/qbnr_div.sv -----
// ----------------------------------------------------------------------------
// qbnr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module qbnr_div #(
  parameter int N_W = 48,
  parameter int D_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [N_W-1:0]       num_i,
  input  logic [D_W-1:0]       den_i,
  output qbnr_pkg::unit_sts_t  sts_o,
  output logic [N_W-1:0]       quo_o
);
  import qbnr_pkg::*;

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [D_W:0]     trial;
  logic [D_W:0]     trial_diff;
  logic             take;
  logic [D_W-1:0]   rem_nxt;
  logic [N_W-1:0]   quo_nxt;

  // One restoring step: shift in the next numerator bit, try the subtract
  always_comb begin
    trial      = {rem_r, quo_r[N_W-1]};
    trial_diff = trial - {1'b0, den_r};
    take       = (trial >= {1'b0, den_r});
    rem_nxt    = take ? trial_diff[D_W-1:0] : trial[D_W-1:0];
    quo_nxt    = {quo_r[N_W-2:0], take};
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        quo_r  <= num_i;
        rem_r  <= '0;
        den_r  <= den_i;
        cnt_r  <= CNT_W'(N_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign quo_o      = quo_r;

endmodule

// ----- rtl/core/qbnr_isqrt.sv -----
// ----------------------------------------------------------------------------
// qbnr_isqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qbnr_isqrt #(
  parameter int X_W = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [X_W-1:0]       x_i,
  output qbnr_pkg::unit_sts_t  sts_o,
  output logic [X_W/2-1:0]     root_o
);
  import qbnr_pkg::*;

  localparam int STEPS = X_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [X_W-1:0]   x_r;
  logic [X_W-1:0]   res_r;
  logic [X_W-1:0]   bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [X_W-1:0]   trial;
  logic [X_W-1:0]   x_nxt;
  logic [X_W-1:0]   res_nxt;

  // One step: compare against res + bit, update remainder and root
  always_comb begin
    trial = res_r + bit_r;
    if (x_r >= trial) begin
      x_nxt   = x_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      x_nxt   = x_r;
      res_nxt = res_r >> 1;
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        x_r    <= x_i;
        res_r  <= '0;
        bit_r  <= X_W'(1) << (X_W - 2);
        cnt_r  <= CNT_W'(STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r   <= x_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign root_o     = res_r[X_W/2-1:0];

endmodule
